[src/coolant_heat_meter_assert.svh]
// ----------------------------------------------------------------------------
// coolant heat meter assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef COOLANT_HEAT_METER_ASSERT_SVH
`define COOLANT_HEAT_METER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CHM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define CHM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also covers the reset cycles
`define CHM_ASSERT_RESET(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

[src/chm_pkg.sv]
// ----------------------------------------------------------------------------
// chm_pkg
// types, register indexes and constants of the coolant heat meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chm_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_GRAMS_PER_PULSE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAT_CAPACITY   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FLOW        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TEMP        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TEMP        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_EMA_WEIGHT      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_DIVIDE     = 3'd6;

   // register reset values
   localparam logic [23:0]        RST_GRAMS_PER_PULSE = 24'd65536;
   localparam logic [19:0]        RST_HEAT_CAPACITY   = 20'd274334;
   localparam logic [31:0]        RST_MIN_FLOW        = 32'd655360;
   localparam logic signed [15:0] RST_MAX_TEMP        = 16'sd7680;
   localparam logic signed [15:0] RST_MIN_TEMP        = 16'sd1280;
   localparam logic [15:0]        RST_EMA_WEIGHT      = 16'd655;
   localparam logic [8:0]         RST_TICK_DIVIDE     = 9'd20;

   // arithmetic constants
   localparam logic signed [15:0] TEMP_HI_Q8 = 16'sd12800;
   localparam logic [9:0]         SCALE_MS   = 10'd1000;
   localparam logic [8:0]         DIV_MIN    = 9'd1;
   localparam logic [8:0]         DIV_MAX    = 9'd256;
   localparam logic [62:0]        MAX63      = {63{1'b1}};
   localparam logic [46:0]        MAX47      = {47{1'b1}};

   // divider sizing: energy magnitude times 1000 over a 32-bit interval
   localparam int DIV_NUM_W = 73;
   localparam int DIV_DEN_W = 32;

   typedef struct packed {
      logic              req_type;
      logic              pin_level;
      logic signed [15:0] temp_in_q8;
      logic signed [15:0] temp_out_q8;
      logic [31:0]       time_ms;
   } req_item_type;

   typedef struct packed {
      logic [31:0]        pulse_count;
      logic [62:0]        total_mass_q16;
      logic signed [63:0] total_energy_q16;
      logic signed [47:0] avg_power_q16;
      logic signed [47:0] avg_flow_q16;
      logic               alarm_flow;
      logic               alarm_temp;
      logic               evaluated;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic decode;
      logic mul_mass;
      logic mul_lo;
      logic mul_hi;
      logic emag;
      logic energy;
      logic div_start;
      logic div_flow;
      logic ema_diff;
      logic ema_mul;
      logic ema_add;
      logic ema_flow;
      logic alarm;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic eval_go;
      logic div_busy;
   } status_type;

endpackage

[src/chm_div.sv]
// ----------------------------------------------------------------------------
// chm_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chm_div #(
   parameter int NUM_W = chm_pkg::DIV_NUM_W,
   parameter int DEN_W = chm_pkg::DIV_DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;

   // shift one numerator bit into the partial remainder and try a subtract
   always_comb begin
      rem_sh  = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      rem_sub = rem_sh - {1'b0, den};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den}) begin
            rem_in = rem_sub;
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

[src/chm_dp.sv]
// ----------------------------------------------------------------------------
// chm_dp
// meter datapath: registers, pulse counting, totals, averages and alarms
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chm_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [chm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [chm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  chm_pkg::req_item_type               req_data,
   input  chm_pkg::cmd_type                    cmd,
   output chm_pkg::status_type                 status,
   output chm_pkg::rsp_item_type               rsp_data
);

   // configuration
   logic [23:0]        gpp_ff;
   logic [19:0]        hc_ff;
   logic [31:0]        min_flow_ff;
   logic signed [15:0] max_temp_ff;
   logic signed [15:0] min_temp_ff;
   logic [15:0]        ema_w_ff;
   logic [8:0]         tick_div_ff;

   // meter state
   chm_pkg::req_item_type req_ff;
   logic               pin_last_ff;
   logic [31:0]        pulses_ff;
   logic [7:0]         tick_phase_ff;
   logic               have_last_ff;
   logic [31:0]        last_time_ff;
   logic [31:0]        last_pulses_ff;
   logic [62:0]        mass_total_ff;
   logic signed [63:0] energy_total_ff;
   logic signed [47:0] power_avg_ff;
   logic signed [47:0] flow_avg_ff;
   logic               alarm_flow_ff;
   logic               alarm_temp_ff;
   logic               evaluated_ff;

   // work registers
   logic [31:0]        dt_ff;
   logic [31:0]        dp_ff;
   logic [13:0]        dmag_ff;
   logic               neg_ff;
   logic [55:0]        mass_ff;
   logic [33:0]        k_ff;
   logic [89:0]        acc_ff;
   logic [62:0]        emag_ff;
   logic signed [48:0] ema_diff_ff;
   logic signed [65:0] ema_prod_ff;
   chm_pkg::rsp_item_type rsp_ff;

   // combinational
   logic [8:0]         div_eff;
   logic [8:0]         phase_inc;
   logic               hit;
   logic               temp_ok;
   logic [31:0]        dt_now;
   logic signed [16:0] dtemp;
   logic signed [16:0] dtemp_abs;
   logic [63:0]        mass_sum;
   logic [62:0]        emag_val;
   logic signed [63:0] energy_j;
   logic signed [64:0] energy_sum;
   logic [72:0]        num_power;
   logic [72:0]        num_flow;
   logic [72:0]        div_num;
   logic               div_busy;
   logic [72:0]        div_quo;
   logic [46:0]        x_mag;
   logic signed [47:0] x_val;
   logic signed [47:0] avg_sel;
   logic signed [65:0] ema_step;
   logic signed [47:0] avg_next;

   // tick decimation and range check
   always_comb begin
      if (tick_div_ff == '0) begin
         div_eff = chm_pkg::DIV_MIN;
      end else if (tick_div_ff > chm_pkg::DIV_MAX) begin
         div_eff = chm_pkg::DIV_MAX;
      end else begin
         div_eff = tick_div_ff;
      end
      phase_inc = {1'b0, tick_phase_ff} + 9'd1;
      hit       = phase_inc >= div_eff;
      temp_ok   = (req_ff.temp_in_q8 >= 16'sd0) && (req_ff.temp_out_q8 >= 16'sd0) &&
                  (req_ff.temp_in_q8 <= chm_pkg::TEMP_HI_Q8) &&
                  (req_ff.temp_out_q8 <= chm_pkg::TEMP_HI_Q8);
      dt_now    = req_ff.time_ms - last_time_ff;
      dtemp     = 17'(req_ff.temp_out_q8) - 17'(req_ff.temp_in_q8);
      dtemp_abs = dtemp[16] ? -dtemp : dtemp;
   end

   assign status.eval_go  = req_ff.req_type && hit && temp_ok && have_last_ff &&
                            (dt_now != '0);
   assign status.div_busy = div_busy;

   // saturating mass total and energy magnitude
   always_comb begin
      mass_sum = {1'b0, mass_total_ff} + {8'b0, mass_ff};
      if (acc_ff[89:87] != '0) begin
         emag_val = chm_pkg::MAX63;
      end else begin
         emag_val = acc_ff[86:24];
      end
      energy_j   = neg_ff ? -$signed({1'b0, emag_ff}) : $signed({1'b0, emag_ff});
      energy_sum = {energy_total_ff[63], energy_total_ff} + {energy_j[63], energy_j};
   end

   // divider numerators
   assign num_power = 73'(emag_ff) * 73'(chm_pkg::SCALE_MS);
   assign num_flow  = 73'(mass_ff) * 73'(chm_pkg::SCALE_MS);
   assign div_num   = cmd.div_flow ? num_flow : num_power;

   chm_div #(
      .NUM_W (chm_pkg::DIV_NUM_W),
      .DEN_W (chm_pkg::DIV_DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (dt_ff),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   // averaging operands
   always_comb begin
      x_mag = (div_quo[72:47] != '0) ? chm_pkg::MAX47 : div_quo[46:0];
      if (cmd.ema_flow) begin
         x_val   = $signed({1'b0, x_mag});
         avg_sel = flow_avg_ff;
      end else begin
         x_val   = neg_ff ? -$signed({1'b0, x_mag}) : $signed({1'b0, x_mag});
         avg_sel = power_avg_ff;
      end
      ema_step = ema_prod_ff >>> 16;
      avg_next = avg_sel + ema_step[47:0];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gpp_ff      <= chm_pkg::RST_GRAMS_PER_PULSE;
         hc_ff       <= chm_pkg::RST_HEAT_CAPACITY;
         min_flow_ff <= chm_pkg::RST_MIN_FLOW;
         max_temp_ff <= chm_pkg::RST_MAX_TEMP;
         min_temp_ff <= chm_pkg::RST_MIN_TEMP;
         ema_w_ff    <= chm_pkg::RST_EMA_WEIGHT;
         tick_div_ff <= chm_pkg::RST_TICK_DIVIDE;
      end else if (csr_we) begin
         unique case (csr_index)
            chm_pkg::CSR_GRAMS_PER_PULSE: gpp_ff      <= csr_wdata[23:0];
            chm_pkg::CSR_HEAT_CAPACITY:   hc_ff       <= csr_wdata[19:0];
            chm_pkg::CSR_MIN_FLOW:        min_flow_ff <= csr_wdata;
            chm_pkg::CSR_MAX_TEMP:        max_temp_ff <= csr_wdata[15:0];
            chm_pkg::CSR_MIN_TEMP:        min_temp_ff <= csr_wdata[15:0];
            chm_pkg::CSR_EMA_WEIGHT:      ema_w_ff    <= csr_wdata[15:0];
            chm_pkg::CSR_TICK_DIVIDE:     tick_div_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // meter state
   always_ff @(posedge clock) begin
      if (reset) begin
         pin_last_ff     <= 1'b0;
         pulses_ff       <= '0;
         tick_phase_ff   <= '0;
         have_last_ff    <= 1'b0;
         last_time_ff    <= '0;
         last_pulses_ff  <= '0;
         mass_total_ff   <= '0;
         energy_total_ff <= '0;
         power_avg_ff    <= '0;
         flow_avg_ff     <= '0;
         alarm_flow_ff   <= 1'b0;
         alarm_temp_ff   <= 1'b0;
         evaluated_ff    <= 1'b0;
      end else begin
         if (cmd.capture) begin
            evaluated_ff <= 1'b0;
         end
         // poll edge count, tick phase and interval bookkeeping
         if (cmd.decode) begin
            if (!req_ff.req_type) begin
               if (req_ff.pin_level && !pin_last_ff) begin
                  pulses_ff <= pulses_ff + 32'd1;
               end
               pin_last_ff <= req_ff.pin_level;
            end else if (hit) begin
               tick_phase_ff <= '0;
               if (temp_ok) begin
                  last_pulses_ff <= pulses_ff;
                  last_time_ff   <= req_ff.time_ms;
                  have_last_ff   <= 1'b1;
               end
            end else begin
               tick_phase_ff <= phase_inc[7:0];
            end
         end
         if (cmd.mul_lo) begin
            mass_total_ff <= mass_sum[63] ? chm_pkg::MAX63 : mass_sum[62:0];
         end
         // saturating signed energy total
         if (cmd.energy) begin
            if (energy_sum[64] != energy_sum[63]) begin
               energy_total_ff <= energy_sum[64] ? {1'b1, 63'b0} : {1'b0, chm_pkg::MAX63};
            end else begin
               energy_total_ff <= energy_sum[63:0];
            end
         end
         if (cmd.ema_add) begin
            if (cmd.ema_flow) begin
               flow_avg_ff <= avg_next;
            end else begin
               power_avg_ff <= avg_next;
            end
         end
         if (cmd.alarm) begin
            alarm_flow_ff <= $signed({flow_avg_ff[47], flow_avg_ff}) <
                             $signed({17'b0, min_flow_ff});
            alarm_temp_ff <= (req_ff.temp_out_q8 > max_temp_ff) ||
                             (req_ff.temp_in_q8 < min_temp_ff);
            evaluated_ff  <= 1'b1;
         end
      end
   end

   // work registers and captured item
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.decode) begin
         dt_ff   <= dt_now;
         dp_ff   <= pulses_ff - last_pulses_ff;
         dmag_ff <= dtemp_abs[13:0];
         neg_ff  <= dtemp[16];
      end
      if (cmd.mul_mass) begin
         mass_ff <= 56'(dp_ff) * 56'(gpp_ff);
         k_ff    <= 34'(hc_ff) * 34'(dmag_ff);
      end
      // energy product in two partial products
      if (cmd.mul_lo) begin
         acc_ff <= 90'(mass_ff[27:0]) * 90'(k_ff);
      end
      if (cmd.mul_hi) begin
         acc_ff <= acc_ff + {62'(mass_ff[55:28]) * 62'(k_ff), 28'b0};
      end
      if (cmd.emag) begin
         emag_ff <= emag_val;
      end
      if (cmd.ema_diff) begin
         ema_diff_ff <= {x_val[47], x_val} - {avg_sel[47], avg_sel};
      end
      if (cmd.ema_mul) begin
         ema_prod_ff <= ema_diff_ff * $signed({1'b0, ema_w_ff});
      end
      // result register
      if (cmd.load_rsp) begin
         rsp_ff.pulse_count      <= pulses_ff;
         rsp_ff.total_mass_q16   <= mass_total_ff;
         rsp_ff.total_energy_q16 <= energy_total_ff;
         rsp_ff.avg_power_q16    <= power_avg_ff;
         rsp_ff.avg_flow_q16     <= flow_avg_ff;
         rsp_ff.alarm_flow       <= alarm_flow_ff;
         rsp_ff.alarm_temp       <= alarm_temp_ff;
         rsp_ff.evaluated        <= evaluated_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

[src/chm_ctrl.sv]
// ----------------------------------------------------------------------------
// chm_ctrl
// sequencer for one item: decode, evaluation steps and result handoff
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  chm_pkg::status_type status,
   output chm_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL_MASS,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_EMAG,
      ST_ENERGY,
      ST_P_WAIT,
      ST_P_DIFF,
      ST_P_MUL,
      ST_P_ADD,
      ST_F_WAIT,
      ST_F_DIFF,
      ST_F_MUL,
      ST_F_ADD,
      ST_ALARM,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state and result slot
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_DECODE;
         ST_DECODE:   state_in = status.eval_go ? ST_MUL_MASS : ST_DONE;
         ST_MUL_MASS: state_in = ST_MUL_LO;
         ST_MUL_LO:   state_in = ST_MUL_HI;
         ST_MUL_HI:   state_in = ST_EMAG;
         ST_EMAG:     state_in = ST_ENERGY;
         ST_ENERGY:   state_in = ST_P_WAIT;
         ST_P_WAIT:   if (!status.div_busy) state_in = ST_P_DIFF;
         ST_P_DIFF:   state_in = ST_P_MUL;
         ST_P_MUL:    state_in = ST_P_ADD;
         ST_P_ADD:    state_in = ST_F_WAIT;
         ST_F_WAIT:   if (!status.div_busy) state_in = ST_F_DIFF;
         ST_F_DIFF:   state_in = ST_F_MUL;
         ST_F_MUL:    state_in = ST_F_ADD;
         ST_F_ADD:    state_in = ST_ALARM;
         ST_ALARM:    state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd           = '0;
      cmd.capture   = (state_ff == ST_IDLE) && req_valid;
      cmd.decode    = (state_ff == ST_DECODE);
      cmd.mul_mass  = (state_ff == ST_MUL_MASS);
      cmd.mul_lo    = (state_ff == ST_MUL_LO);
      cmd.mul_hi    = (state_ff == ST_MUL_HI);
      cmd.emag      = (state_ff == ST_EMAG);
      cmd.energy    = (state_ff == ST_ENERGY);
      cmd.div_start = (state_ff == ST_ENERGY) || (state_ff == ST_P_ADD);
      cmd.div_flow  = (state_ff == ST_P_ADD);
      cmd.ema_diff  = (state_ff == ST_P_DIFF) || (state_ff == ST_F_DIFF);
      cmd.ema_mul   = (state_ff == ST_P_MUL) || (state_ff == ST_F_MUL);
      cmd.ema_add   = (state_ff == ST_P_ADD) || (state_ff == ST_F_ADD);
      cmd.ema_flow  = (state_ff == ST_F_DIFF) || (state_ff == ST_F_MUL) ||
                      (state_ff == ST_F_ADD);
      cmd.alarm     = (state_ff == ST_ALARM);
      cmd.load_rsp  = (state_ff == ST_DONE) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[src/coolant_heat_meter.sv]
// a poll sample or a tick that does not update totals goes from decode straight
// to the result slot; an updating tick also waits twice on the one-bit-per-cycle
// divider (73 quotient bits each), first for the power and then for the flow
// one item at a time: the next item is taken only once the block is back in idle
// reset: synchronous, active high; clears counters, totals, averages, alarms
// and loads the configuration defaults
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// coolant_heat_meter
// thermal energy meter: flow pulse counting, energy totals, power and flow averages
// ----------------------------------------------------------------------------
module coolant_heat_meter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  chm_pkg::req_item_type          req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output chm_pkg::rsp_item_type          rsp_data,
   input  logic                           csr_we,
   input  logic [chm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [chm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   chm_pkg::cmd_type    cmd;
   chm_pkg::status_type status;

   // sequencer
   chm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and state
   chm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

[src/chm_checker.sv]
// ----------------------------------------------------------------------------
// chm_checker
// port-level checks of the coolant heat meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "coolant_heat_meter_assert.svh"

module chm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input chm_pkg::req_item_type          req_data,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input chm_pkg::rsp_item_type          rsp_data,
   input logic                           csr_we,
   input logic [chm_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [chm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // a stalled result stays offered and unchanged
   `CHM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
   `CHM_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data), "result changed")

   // one item at a time: input closes right after a transfer
   `CHM_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready, "second item taken")

   // reset leaves no result pending and the input open
   `CHM_ASSERT_RESET(a_reset_idle, reset, !rsp_valid && req_ready, "bad state after reset")

endmodule

bind coolant_heat_meter chm_checker u_chm_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the coolant heat meter: directed edge detection,
// zero elapsed time, temperature window and time wrap, register extremes
// and decimation, then mostly well-formed random traffic, varied idle and stall
// ----------------------------------------------------------------------------
module tb_top;

   localparam int DRAIN_CYCLES = 240;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   chm_pkg::req_item_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   chm_pkg::rsp_item_type rsp_data;
   logic csr_we = 1'b0;
   logic [chm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [chm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // meter model state
   logic [23:0]        m_gpp;
   logic [19:0]        m_heat_cap;
   logic [31:0]        m_min_flow;
   logic signed [15:0] m_max_temp;
   logic signed [15:0] m_min_temp;
   logic [15:0]        m_weight;
   logic [8:0]         m_divide;
   logic               m_pin_last;
   logic [31:0]        m_pulses;
   logic [7:0]         m_phase;
   logic               m_have_last;
   logic [31:0]        m_last_time;
   logic [31:0]        m_last_pulses;
   logic [62:0]        m_mass_total;
   longint             m_energy_total;
   longint             m_power_avg;
   longint             m_flow_avg;
   logic [1:0]         m_alarms;

   chm_pkg::rsp_item_type meter_readings[$];

   int errors = 0;
   int sent_items = 0;
   int seen_results = 0;
   int seen_updates = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   logic pin_drive = 1'b0;
   logic [31:0] clock_ms = 32'd0;

   coolant_heat_meter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // overall time limit
   initial begin
      #60_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic void meter_reset();
      m_gpp = chm_pkg::RST_GRAMS_PER_PULSE;
      m_heat_cap = chm_pkg::RST_HEAT_CAPACITY;
      m_min_flow = chm_pkg::RST_MIN_FLOW;
      m_max_temp = chm_pkg::RST_MAX_TEMP;
      m_min_temp = chm_pkg::RST_MIN_TEMP;
      m_weight = chm_pkg::RST_EMA_WEIGHT;
      m_divide = chm_pkg::RST_TICK_DIVIDE;
      m_pin_last = 1'b0;
      m_pulses = '0;
      m_phase = '0;
      m_have_last = 1'b0;
      m_last_time = '0;
      m_last_pulses = '0;
      m_mass_total = '0;
      m_energy_total = 0;
      m_power_avg = 0;
      m_flow_avg = 0;
      m_alarms = '0;
   endfunction

   // floor(a * 1000 / d) capped at 2^47-1
   function automatic logic [63:0] rate_per_second(logic [63:0] a, logic [31:0] d);
      logic [127:0] q;
      q = ({64'd0, a} * 128'd1000) / {96'd0, d};
      return (q > {81'd0, chm_pkg::MAX47}) ? {17'd0, chm_pkg::MAX47} : q[63:0];
   endfunction

   // exponential average step, rounding toward minus infinity
   function automatic longint blend_average(longint avg, longint x);
      logic signed [95:0] prod;
      longint diff;
      diff = x - avg;
      prod = 96'(diff) * $signed({1'b0, m_weight});
      return avg + longint'(prod >>> 16);
   endfunction

   function automatic void update_totals(logic signed [15:0] ti, logic signed [15:0] to,
                                         logic [31:0] now, output logic done);
      logic [31:0] dt;
      logic [63:0] mass;
      logic [63:0] emag;
      logic [127:0] prod;
      logic [63:0] pmag;
      logic [63:0] fmag;
      logic signed [65:0] sum;
      int dtemp;
      longint j;
      done = 1'b0;
      dt = now - m_last_time;
      if (m_have_last && dt != 0) begin
         mass = 64'(m_pulses - m_last_pulses) * 64'(m_gpp);
         dtemp = int'(to) - int'(ti);
         m_mass_total = ({1'b0, m_mass_total} + mass > {1'b0, chm_pkg::MAX63}) ?
                        chm_pkg::MAX63 : m_mass_total + mass[62:0];
         prod = 128'(mass) * 128'(m_heat_cap) * 128'(dtemp < 0 ? -dtemp : dtemp);
         prod = prod >> 24;
         emag = (prod > {65'd0, chm_pkg::MAX63}) ? {1'b0, chm_pkg::MAX63} : prod[63:0];
         j = (dtemp < 0) ? -longint'(emag) : longint'(emag);
         sum = 66'(m_energy_total) + 66'(j);
         if (sum > 66'sh0_7FFF_FFFF_FFFF_FFFF) m_energy_total = 64'h7FFF_FFFF_FFFF_FFFF;
         else if (sum < -66'sh0_8000_0000_0000_0000)
            m_energy_total = 64'h8000_0000_0000_0000;
         else m_energy_total = longint'(sum);
         pmag = rate_per_second(emag, dt);
         m_power_avg = blend_average(m_power_avg,
                                     (dtemp < 0) ? -longint'(pmag) : longint'(pmag));
         fmag = rate_per_second(mass, dt);
         m_flow_avg = blend_average(m_flow_avg, longint'(fmag));
         m_alarms[0] = m_flow_avg < longint'({32'd0, m_min_flow});
         m_alarms[1] = (to > m_max_temp) || (ti < m_min_temp);
         done = 1'b1;
      end
      m_last_pulses = m_pulses;
      m_last_time = now;
      m_have_last = 1'b1;
   endfunction

   function automatic chm_pkg::rsp_item_type predict_reading(chm_pkg::req_item_type item);
      chm_pkg::rsp_item_type r;
      logic done;
      int div;
      done = 1'b0;
      if (!item.req_type) begin
         if (item.pin_level && !m_pin_last) m_pulses = m_pulses + 1;
         m_pin_last = item.pin_level;
      end else begin
         div = (m_divide == 0) ? 1 : (m_divide > chm_pkg::DIV_MAX) ? 256 : int'(m_divide);
         if (int'(m_phase) + 1 >= div) begin
            m_phase = '0;
            if (item.temp_in_q8 >= 0 && item.temp_out_q8 >= 0 &&
                item.temp_in_q8 <= chm_pkg::TEMP_HI_Q8 &&
                item.temp_out_q8 <= chm_pkg::TEMP_HI_Q8)
               update_totals(item.temp_in_q8, item.temp_out_q8, item.time_ms, done);
         end else begin
            m_phase = m_phase + 8'd1;
         end
      end
      r.pulse_count = m_pulses;
      r.total_mass_q16 = m_mass_total;
      r.total_energy_q16 = m_energy_total;
      r.avg_power_q16 = m_power_avg[47:0];
      r.avg_flow_q16 = m_flow_avg[47:0];
      r.alarm_flow = m_alarms[0];
      r.alarm_temp = m_alarms[1];
      r.evaluated = done;
      return r;
   endfunction

   // one transfer on the request channel, then an optional gap
   task automatic send_item(chm_pkg::req_item_type item);
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      meter_readings.push_back(predict_reading(item));
      sent_items++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_poll(logic level);
      chm_pkg::req_item_type item;
      item.req_type = 1'b0;
      item.pin_level = level;
      item.temp_in_q8 = 16'($urandom);
      item.temp_out_q8 = 16'($urandom);
      item.time_ms = $urandom;
      send_item(item);
   endtask

   task automatic send_tick(logic signed [15:0] ti, logic signed [15:0] to, logic [31:0] t);
      chm_pkg::req_item_type item;
      item.req_type = 1'b1;
      item.pin_level = 1'($urandom_range(1));
      item.temp_in_q8 = ti;
      item.temp_out_q8 = to;
      item.time_ms = t;
      send_item(item);
   endtask

   // wait for every result, then for the block to go idle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (meter_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [chm_pkg::CSR_IDX_W-1:0] idx,
                            logic [chm_pkg::CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         chm_pkg::CSR_GRAMS_PER_PULSE: m_gpp = value[23:0];
         chm_pkg::CSR_HEAT_CAPACITY:   m_heat_cap = value[19:0];
         chm_pkg::CSR_MIN_FLOW:        m_min_flow = value;
         chm_pkg::CSR_MAX_TEMP:        m_max_temp = value[15:0];
         chm_pkg::CSR_MIN_TEMP:        m_min_temp = value[15:0];
         chm_pkg::CSR_EMA_WEIGHT:      m_weight = value[15:0];
         chm_pkg::CSR_TICK_DIVIDE:     m_divide = value[8:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // mostly well-formed flow traffic with valid ticks, some noise
   task automatic run_traffic(int count);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 55) begin
            if ($urandom_range(99) < 75) pin_drive = ~pin_drive;
            send_poll(pin_drive);
         end else if (r < 90) begin
            case ($urandom_range(19))
               0:       clock_ms = clock_ms;
               1:       clock_ms = clock_ms + $urandom;
               2:       clock_ms = clock_ms + $urandom_range(1, 3);
               default: clock_ms = clock_ms + $urandom_range(1, 3000);
            endcase
            send_tick(16'($urandom_range(0, 12800)), 16'($urandom_range(0, 12800)),
                      clock_ms);
         end else begin
            send_tick(16'($urandom), 16'($urandom), $urandom);
         end
      end
   endtask

   task automatic test_directed();
      write_reg(chm_pkg::CSR_TICK_DIVIDE, 32'd1);
      send_poll(1'b0);
      send_poll(1'b1);
      send_poll(1'b1);
      send_poll(1'b0);
      // first accepted tick only records time and pulses
      send_tick(16'sd0, 16'sd12800, 32'd1000);
      repeat (3) begin
         send_poll(1'b1);
         send_poll(1'b0);
      end
      // zero elapsed time
      send_tick(16'sd0, 16'sd12800, 32'd1000);
      send_poll(1'b1);
      send_tick(16'sd0, 16'sd12800, 32'd1005);
      // outside the temperature window
      send_tick(-16'sd1, 16'sd100, 32'd1100);
      send_tick(16'sd100, 16'sd12801, 32'd1100);
      send_tick(-16'sd32768, 16'sd32767, 32'hFFFF_FFFF);
      // negative temperature rise
      send_poll(1'b0);
      send_poll(1'b1);
      send_tick(16'sd12800, 16'sd0, 32'd1200);
      // time stamp wraps
      send_tick(16'sd1000, 16'sd2000, 32'hFFFF_FFF0);
      send_poll(1'b0);
      send_poll(1'b1);
      send_tick(16'sd1000, 16'sd2000, 32'd4);
      drain();
   endtask

   task automatic test_register_extremes();
      write_reg(chm_pkg::CSR_GRAMS_PER_PULSE, 32'hFF_FFFF);
      write_reg(chm_pkg::CSR_HEAT_CAPACITY, 32'hF_FFFF);
      write_reg(chm_pkg::CSR_MIN_FLOW, 32'hFFFF_FFFF);
      write_reg(chm_pkg::CSR_MAX_TEMP, 32'h0000_8000);
      write_reg(chm_pkg::CSR_MIN_TEMP, 32'h0000_7FFF);
      write_reg(chm_pkg::CSR_EMA_WEIGHT, 32'hFFFF);
      write_reg(chm_pkg::CSR_TICK_DIVIDE, 32'd0);
      run_traffic(120);
      drain();
      write_reg(chm_pkg::CSR_GRAMS_PER_PULSE, 32'd0);
      write_reg(chm_pkg::CSR_HEAT_CAPACITY, 32'd0);
      write_reg(chm_pkg::CSR_MIN_FLOW, 32'd0);
      write_reg(chm_pkg::CSR_MAX_TEMP, 32'h0000_7FFF);
      write_reg(chm_pkg::CSR_MIN_TEMP, 32'h0000_8000);
      write_reg(chm_pkg::CSR_EMA_WEIGHT, 32'd0);
      write_reg(chm_pkg::CSR_TICK_DIVIDE, 32'd511);
      run_traffic(40);
      drain();
      write_reg(chm_pkg::CSR_TICK_DIVIDE, 32'd256);
      write_reg(chm_pkg::CSR_EMA_WEIGHT, 32'd40000);
      for (int n = 0; n < 300; n++) begin
         clock_ms = clock_ms + $urandom_range(1, 50);
         send_tick(16'($urandom_range(0, 12800)), 16'($urandom_range(0, 12800)), clock_ms);
      end
      drain();
   endtask

   task automatic test_random_traffic();
      int idle_plan[4] = '{0, 64, 0, 11};
      int stall_plan[4] = '{0, 0, 64, 11};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_plan[p];
         stall_pct = stall_plan[p];
         write_reg(chm_pkg::CSR_GRAMS_PER_PULSE, $urandom_range(1, 24'hFF_FFFF));
         write_reg(chm_pkg::CSR_HEAT_CAPACITY, $urandom_range(0, 20'hF_FFFF));
         write_reg(chm_pkg::CSR_MIN_FLOW, $urandom);
         write_reg(chm_pkg::CSR_MAX_TEMP, $urandom_range(0, 12800));
         write_reg(chm_pkg::CSR_MIN_TEMP, $urandom_range(0, 12800));
         write_reg(chm_pkg::CSR_EMA_WEIGHT, $urandom_range(0, 16'hFFFF));
         write_reg(chm_pkg::CSR_TICK_DIVIDE, $urandom_range(1, 3));
         run_traffic(80);
         // hold off until the meter has answered everything
         if (p == 1) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (meter_readings.size() != 0) @(posedge clock);
         end
         run_traffic(80);
         drain();
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
      end
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // check each result transfer against the oldest prediction
   always @(posedge clock) begin
      chm_pkg::rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen_results++;
         if (meter_readings.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got %h", $realtime, rsp_data);
         end else begin
            want = meter_readings.pop_front();
            if (want.evaluated) seen_updates++;
            compare_field("pulse_count", want.pulse_count, rsp_data.pulse_count);
            compare_field("total_mass", want.total_mass_q16, rsp_data.total_mass_q16);
            compare_field("total_energy", want.total_energy_q16, rsp_data.total_energy_q16);
            compare_field("avg_power", want.avg_power_q16, rsp_data.avg_power_q16);
            compare_field("avg_flow", want.avg_flow_q16, rsp_data.avg_flow_q16);
            compare_field("alarm_flow", want.alarm_flow, rsp_data.alarm_flow);
            compare_field("alarm_temp", want.alarm_temp, rsp_data.alarm_temp);
            compare_field("evaluated", want.evaluated, rsp_data.evaluated);
         end
      end
   end

   // test sequence
   initial begin
      meter_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_extremes();
      test_random_traffic();
      drain();
      if (meter_readings.size() != 0) begin
         errors++;
         $display("%0t: %0d results never arrived", $realtime, meter_readings.size());
      end
      $display("covered %0d items and %0d results, %0d of them updating the totals",
               sent_items, seen_results, seen_updates);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
